### rtl/mfkc_pkg.sv
// package for the most frequent k-mer counter
// shared constants and types; no dependencies
`default_nettype none
package mfkc_pkg;
    localparam int KMER_MAX_DEF      = 8;
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int KLEN_W            = 4;
    localparam int SYM_W             = 8;
    localparam int CNT_W             = 32;
    localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_SCAN,
        ST_SCAN_CHECK,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

### rtl/mfkc_table.sv
// entry table: key and count memories, one read port and one write port each
// depends on mfkc_pkg
`default_nettype none
module mfkc_table
    import mfkc_pkg::*;
#(
    parameter int KEY_W = 64,
    parameter int AW    = 8
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [KEY_W-1:0]  rd_key,
    output logic      [CNT_W-1:0]  rd_count,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [KEY_W-1:0]  wr_key,
    input  wire logic [CNT_W-1:0]  wr_count
);
    logic [KEY_W-1:0] key_mem [2**AW];
    logic [CNT_W-1:0] cnt_mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            cnt_mem[wr_addr] <= wr_count;
        end
        if (rd_en)
        begin
            rd_key   <= key_mem[rd_addr];
            rd_count <= cnt_mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

### rtl/most_frequent_kmer_counter_core.sv
// most frequent k-mer counter: sequencer, window and result register
// depends on mfkc_pkg and mfkc_table
//
// usage: symbols arrive on the in channel (in_valid / in_ready) with
// final_symbol marking the last one. kmer_length is written through
// cfg_we / cfg_wdata while idle. a symbol that completes no k-mer needs
// no table access. any other symbol runs a linear probe of the entry table:
// one memory read per used entry (fewer on an early hit); each probe step
// is a read state followed by a compare state.
// the final symbol adds a scan of all used entries, a read and a compare
// state per entry, then one result transfer on the out channel
// (out_valid / out_ready).
// the result sits in an output register; the block waits while the
// receiver stalls and takes the next symbol once the result is taken.
// reset clears window, counters, fill count, overflow flag and sets k to 4.
// the table has no clearing pass: the fill count marks which entries exist.
`default_nettype none
module most_frequent_kmer_counter_core
    import mfkc_pkg::*;
#(
    parameter int KMER_MAX      = KMER_MAX_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [KLEN_W-1:0]     cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [SYM_W-1:0]      symbol,
    input  wire logic                  final_symbol,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [SYM_W*KMER_MAX-1:0]  best_kmer,
    output logic [CNT_W-1:0]           best_count,
    output logic                       found,
    output logic                       table_overflow
);
    localparam int KEY_W = SYM_W * KMER_MAX;
    localparam int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int UW    = $clog2(TABLE_ENTRIES + 1);
    localparam int SW    = $clog2(KMER_MAX + 1);
    localparam logic [UW-1:0] TABLE_FULL = UW'(TABLE_ENTRIES);

    state_t state_reg, state_next;
    logic [KLEN_W-1:0] klen_reg;
    logic [KEY_W-1:0]  window_reg, window_next;
    logic [SW-1:0]     seen_reg, seen_next;
    logic [UW-1:0]     used_reg, used_next;
    logic              ovf_reg, ovf_next;
    logic              last_reg, last_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [UW-1:0]     idx_reg, idx_next;
    logic [KEY_W-1:0]  bkey_reg, bkey_next;
    logic [CNT_W-1:0]  bcnt_reg, bcnt_next;
    logic              bfound_reg, bfound_next;

    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [KEY_W-1:0]  rd_key, wr_key;
    logic [CNT_W-1:0]  rd_count, wr_count;

    logic [SW-1:0]     keff;
    logic [KEY_W-1:0]  kmask, win_shift;
    logic              in_xfer;

    mfkc_table #(.KEY_W(KEY_W), .AW(AW)) u_table (
        .clk(clk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_key(rd_key),
        .rd_count(rd_count), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_key(wr_key), .wr_count(wr_count)
    );

    always_comb
    begin
        if (klen_reg == '0)
            keff = SW'(1);
        else if (32'(klen_reg) > KMER_MAX)
            keff = SW'(KMER_MAX);
        else
            keff = SW'(klen_reg);
        kmask = '0;
        for (int b = 0; b < KMER_MAX; b++)
        begin
            if (b < 32'(keff))
                kmask[b*SYM_W +: SYM_W] = {SYM_W{1'b1}};
        end
    end

    assign in_xfer   = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign best_kmer = bkey_reg;
    assign best_count = bcnt_reg;
    assign found     = bfound_reg;
    assign table_overflow = ovf_reg;
    assign win_shift = (window_reg << SYM_W) | KEY_W'(symbol);
    assign rd_addr   = idx_reg[AW-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (32'(seen_next) >= 32'(keff))
                        state_next = ST_PROBE;
                    else if (final_symbol)
                        state_next = ST_SCAN;
                end
            end
            ST_PROBE:
            begin
                if (idx_reg < used_reg)
                    state_next = ST_CHECK;
                else
                    state_next = last_reg ? ST_SCAN : ST_IDLE;
            end
            ST_CHECK:
            begin
                if (rd_key == key_reg)
                    state_next = last_reg ? ST_SCAN : ST_IDLE;
                else
                    state_next = ST_PROBE;
            end
            ST_SCAN:
            begin
                if (idx_reg < used_reg)
                    state_next = ST_SCAN_CHECK;
                else
                    state_next = ST_OUT;
            end
            ST_SCAN_CHECK: state_next = ST_SCAN;
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        window_next = window_reg;
        seen_next   = seen_reg;
        used_next   = used_reg;
        ovf_next    = ovf_reg;
        last_next   = last_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        bkey_next   = bkey_reg;
        bcnt_next   = bcnt_reg;
        bfound_next = bfound_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = used_reg[AW-1:0];
        wr_key      = key_reg;
        wr_count    = CNT_W'(1);
        if (32'(seen_reg) < KMER_MAX && in_xfer)
            seen_next = seen_reg + SW'(1);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    window_next = win_shift;
                    key_next    = win_shift & kmask;
                    last_next   = final_symbol;
                    idx_next    = '0;
                    bkey_next   = '0;
                    bcnt_next   = '0;
                    bfound_next = 1'b0;
                end
            end
            ST_PROBE:
            begin
                if (idx_reg < used_reg)
                    rd_en = 1'b1;
                else
                begin
                    idx_next = '0;
                    if (used_reg < TABLE_FULL)
                    begin
                        wr_en     = 1'b1;
                        used_next = used_reg + UW'(1);
                    end
                    else
                        ovf_next = 1'b1;
                end
            end
            ST_CHECK:
            begin
                if (rd_key == key_reg)
                begin
                    idx_next = '0;
                    wr_en    = (rd_count != '1);
                    wr_addr  = idx_reg[AW-1:0] - AW'(1);
                    wr_count = rd_count + CNT_W'(1);
                end
            end
            ST_SCAN:
            begin
                if (idx_reg < used_reg)
                    rd_en = 1'b1;
            end
            ST_SCAN_CHECK:
            begin
                if (!bfound_reg || rd_count > bcnt_reg ||
                    (rd_count == bcnt_reg && rd_key < bkey_reg))
                begin
                    bkey_next   = rd_key;
                    bcnt_next   = rd_count;
                    bfound_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    window_next = '0;
                    seen_next   = '0;
                    used_next   = '0;
                    ovf_next    = 1'b0;
                end
            end
            default: ;
        endcase
        if (rd_en)
            idx_next = idx_reg + UW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            klen_reg   <= KLEN_RESET;
            window_reg <= '0;
            seen_reg   <= '0;
            used_reg   <= '0;
            ovf_reg    <= 1'b0;
            last_reg   <= 1'b0;
            idx_reg    <= '0;
            bfound_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            if (cfg_we)
                klen_reg <= cfg_wdata;
            window_reg <= window_next;
            seen_reg   <= seen_next;
            used_reg   <= used_next;
            ovf_reg    <= ovf_next;
            last_reg   <= last_next;
            idx_reg    <= idx_next;
            bfound_reg <= bfound_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        bkey_reg <= bkey_next;
        bcnt_reg <= bcnt_next;
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= TABLE_FULL)
        else $error("fill count beyond table size");
    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> best_count != '0)
        else $error("found result with zero count");
    a_no_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> best_count == '0 && best_kmer == '0)
        else $error("empty result not zero");
    a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> used_reg == '0 && !ovf_reg)
        else $error("table not cleared after result");
endmodule
`default_nettype wire

### sim/most_frequent_kmer_counter_core_tb.sv
// testbench for most_frequent_kmer_counter_core: directed and random symbol streams
// checked against an in-bench k-mer table predictor; depends on mfkc_pkg and the core rtl
`timescale 1ns / 1ps
module most_frequent_kmer_counter_core_tb;
    import mfkc_pkg::*;

    localparam int KMAX     = KMER_MAX_DEF;
    localparam int ENTRIES  = TABLE_ENTRIES_DEF;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [SYM_W*KMAX-1:0] kmer;
        logic [CNT_W-1:0]      count;
        logic                  found;
        logic                  ovf;
    } winner_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [KLEN_W-1:0]        cfg_wdata;
    logic                     in_valid;
    logic                     in_ready;
    logic [SYM_W-1:0]         symbol;
    logic                     final_symbol;
    logic                     out_valid;
    logic                     out_ready;
    logic [SYM_W*KMAX-1:0]    best_kmer;
    logic [CNT_W-1:0]         best_count;
    logic                     found;
    logic                     table_overflow;

    most_frequent_kmer_counter_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .symbol(symbol), .final_symbol(final_symbol),
        .out_valid(out_valid), .out_ready(out_ready),
        .best_kmer(best_kmer), .best_count(best_count),
        .found(found), .table_overflow(table_overflow)
    );

    // predictor state
    logic [KLEN_W-1:0]     k_reg;
    logic [SYM_W*KMAX-1:0] win;
    int                    seen;
    logic [SYM_W*KMAX-1:0] keys [ENTRIES];
    logic [CNT_W-1:0]      counts [ENTRIES];
    int                    used;
    bit                    ovf_flag;

    winner_t winner_q[$];
    int      mismatches;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_req;
    int      hold_left;
    int      quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_table();
        win = '0;
        seen = 0;
        used = 0;
        ovf_flag = 1'b0;
    endfunction

    function automatic void count_symbol(logic [SYM_W-1:0] s, logic fin);
        int k;
        logic [SYM_W*KMAX-1:0] key;
        bit hit;
        winner_t w;
        k = k_reg;
        if (k < 1) k = 1;
        if (k > KMAX) k = KMAX;
        win = {win[SYM_W*KMAX-SYM_W-1:0], s};
        if (seen < KMAX) seen++;
        if (seen >= k)
        begin
            key = (k >= KMAX) ? win : (win & ((64'd1 << (8 * k)) - 64'd1));
            hit = 1'b0;
            for (int i = 0; i < used; i++)
            begin
                if (!hit && keys[i] == key)
                begin
                    if (counts[i] != '1) counts[i]++;
                    hit = 1'b1;
                end
            end
            if (!hit)
            begin
                if (used < ENTRIES)
                begin
                    keys[used] = key;
                    counts[used] = CNT_W'(1);
                    used++;
                end
                else
                    ovf_flag = 1'b1;
            end
        end
        if (fin)
        begin
            w.kmer = '0;
            w.count = '0;
            w.found = 1'b0;
            for (int i = 0; i < used; i++)
            begin
                if (!w.found || counts[i] > w.count ||
                    (counts[i] == w.count && keys[i] < w.kmer))
                begin
                    w.kmer = keys[i];
                    w.count = counts[i];
                    w.found = 1'b1;
                end
            end
            w.ovf = ovf_flag;
            winner_q.insert(winner_q.size(), w);
            clear_table();
        end
    endfunction

    // result checking, receiver stalls and watchdog
    always @(posedge clk)
    begin
        winner_t w;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                if (winner_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer kmer=%h", best_kmer);
                end
                else
                begin
                    w = winner_q.pop_front();
                    if (best_kmer !== w.kmer || best_count !== w.count ||
                        found !== w.found || table_overflow !== w.ovf)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch exp kmer=%h cnt=%0d f=%b o=%b ",
                                "got kmer=%h cnt=%0d f=%b o=%b"},
                                w.kmer, w.count, w.found, w.ovf,
                                best_kmer, best_count, found, table_overflow);
                    end
                end
            end
        end
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_symbol(input logic [SYM_W-1:0] s, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        symbol <= s;
        final_symbol <= fin;
        do @(posedge clk); while (!in_ready);
        count_symbol(s, fin);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (winner_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_k(input logic [KLEN_W-1:0] v);
        wait_drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        k_reg = v;
    endtask

    task automatic send_string(input string str);
        for (int i = 0; i < str.len(); i++)
            send_symbol(str[i], i == str.len() - 1);
    endtask

    task automatic test_directed();
        send_string("ab");
        send_string("abcabcab");
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hff, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hff, 1'b1);
        write_k(4'd1);
        send_string("zyzx");
        write_k(4'd0);
        send_string("qq");
        write_k(4'd8);
        send_string("abcdefghab");
        write_k(4'd15);
        send_symbol(8'hff, 1'b0);
        send_symbol(8'hff, 1'b1);
    endtask

    task automatic test_overflow();
        write_k(4'd2);
        for (int i = 0; i < 330; i++)
            send_symbol(i[7:0] ^ {i[9:8], 6'd0}, 1'b0);
        send_symbol(8'h11, 1'b1);
        wait_drain();
    endtask

    task automatic test_backpressure();
        wait_drain();
        hold_req = 3000;
        @(posedge clk);
        for (int n = 0; n < 4; n++)
            for (int i = 0; i < 5; i++)
                send_symbol(SYM_W'($urandom_range(65, 68)), i == 4);
        wait_drain();
    endtask

    task automatic random_phase(input int s_pct, input int r_pct, input int items);
        int sent;
        int len;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(3) == 0)
                write_k(KLEN_W'($urandom_range(15)));
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(9) < 7)
                    send_symbol(SYM_W'($urandom_range(97, 99)), i == len - 1);
                else
                    send_symbol(SYM_W'($urandom_range(255)), i == len - 1);
            end
            sent += len;
        end
        wait_drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        symbol = '0;
        final_symbol = 1'b0;
        out_ready = 1'b0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 0;
        hold_left = 0;
        quiet_cycles = 0;
        k_reg = KLEN_RESET;
        clear_table();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_overflow();
        test_backpressure();
        random_phase(35, 76, 130);
        random_phase(76, 35, 130);
        random_phase(0, 0, 130);

        wait_drain();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && winner_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
